/* hdl/swbc_pkg.sv */
// Shared constants, types and register indexes for the sliding-window base-count check.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package swbc_pkg;

  // Sizing of the window store and the qualifying-window counter.
  localparam int WINDOW_MAX = 1024;
  localparam int COUNT_BITS = 20;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

  // Symbol coding.
  localparam int NUM_BASES = 4;
  localparam int BASE_W    = 2;
  localparam logic [BASE_W-1:0] BASE_A = 2'd0;
  localparam logic [BASE_W-1:0] BASE_C = 2'd1;
  localparam logic [BASE_W-1:0] BASE_G = 2'd2;
  localparam logic [BASE_W-1:0] BASE_T = 2'd3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_A         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_C         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_G         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_T         = 3'd4;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified request as the back sees it.
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              start_new;
    logic              evict;
    logic              full;
    logic [BASE_W-1:0] gone;
  } swbc_item_t;

  // Per-base minimums, indexed by base code.
  typedef logic [NUM_BASES-1:0][CFG_DATA_W-1:0] swbc_mins_t;

endpackage

`default_nettype wire

/* hdl/swbc_front.sv */
// Front part: accepts symbols, tracks the window fill and owns the symbol ring.
// Depends on swbc_pkg; feeds classified requests into swbc_fifo.
`default_nettype none

module swbc_front import swbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              seq_clear,
  input  wire logic [LEN_W-1:0]  win_len,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [BASE_W-1:0] in_base,
  input  wire logic              in_start_new,
  output logic                   q_push,
  output swbc_item_t             q_data,
  input  wire logic              q_full
);

  // Symbol ring, read and written once per accepted request.
  logic [BASE_W-1:0] ring_mem [WINDOW_MAX];
  logic [BASE_W-1:0] ring_rd_r;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  swbc_item_t       s1_r, s1_nxt;

  logic             accept;
  logic [LEN_W-1:0] fill_base;
  logic             evict;
  logic [PTR_W-1:0] rd_addr;

  // A request waits in the stage register until the queue has room.
  assign in_full = s1_valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = s1_valid_r & ~q_full;

  // Classify: a full window loses its oldest symbol as the new one enters.
  always_comb begin
    fill_base = in_start_new ? '0 : fill_r;
    evict     = (fill_base >= win_len);
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    if (accept) begin
      fill_nxt = evict ? fill_base : fill_base + LEN_W'(1);
      wp_nxt   = wp_r + PTR_W'(1);
    end
    // The oldest symbol sits one window length behind the write pointer.
    rd_addr = wp_r - PTR_W'(win_len);

    s1_nxt           = s1_r;
    s1_nxt.base      = in_base;
    s1_nxt.start_new = in_start_new;
    s1_nxt.evict     = evict;
    s1_nxt.full      = (fill_nxt == win_len);
    s1_nxt.gone      = '0;

    s1_valid_nxt = accept | (s1_valid_r & q_full);
  end

  assign q_data = '{base:      s1_r.base,
                    start_new: s1_r.start_new,
                    evict:     s1_r.evict,
                    full:      s1_r.full,
                    gone:      ring_rd_r};

  // Ring access: the read returns the entry as it was before this write.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd_r         <= ring_mem[rd_addr];
      ring_mem[wp_r]    <= in_base;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      fill_r     <= seq_clear ? '0 : fill_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/swbc_fifo.sv */
// Short queue of classified requests between the front and the back.
// Depends on swbc_pkg for the entry type and depth.
`default_nettype none

module swbc_fifo import swbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire swbc_item_t push_data,
  output logic            full,
  input  wire logic       pop,
  output swbc_item_t      head,
  output logic            empty
);

  swbc_item_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* hdl/swbc_back.sv */
// Back part: updates the per-base counts, checks the minimums and counts qualifying windows.
// Depends on swbc_pkg; takes requests from swbc_fifo and holds the result register.
`default_nettype none

module swbc_back import swbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              seq_clear,
  input  wire swbc_mins_t        mins,
  input  wire logic              q_empty,
  input  wire swbc_item_t        q_head,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_window_full,
  output logic                   out_window_ok,
  output logic [COUNT_BITS-1:0]  out_match_count
);

  logic [NUM_BASES-1:0][LEN_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]           qual_r, qual_nxt;
  logic                            out_valid_r;
  logic                            res_full_r, res_ok_r;

  logic [NUM_BASES-1:0][LEN_W-1:0] cnt_base;
  logic [NUM_BASES-1:0]            meet;
  logic [COUNT_BITS-1:0]           qual_base;
  logic                            ok;

  // Take the next request whenever the result register is free or being drained.
  assign q_pop     = ~q_empty & (~out_valid_r | out_pop);
  assign out_empty = ~out_valid_r;

  // Count update, minimum check and saturating window count.
  always_comb begin
    for (int i = 0; i < NUM_BASES; i++) begin
      cnt_base[i] = q_head.start_new ? '0 : cnt_r[i];
      cnt_nxt[i]  = cnt_base[i];
      if (q_head.evict && (q_head.gone == BASE_W'(i)) && (cnt_base[i] != '0)) begin
        cnt_nxt[i] = cnt_nxt[i] - LEN_W'(1);
      end
      if (q_head.base == BASE_W'(i)) begin
        cnt_nxt[i] = cnt_nxt[i] + LEN_W'(1);
      end
      meet[i] = (32'(cnt_nxt[i]) >= 32'(mins[i]));
    end
    ok        = q_head.full & (&meet);
    qual_base = q_head.start_new ? '0 : qual_r;
    qual_nxt  = qual_base;
    if (ok && (qual_base != '1)) begin
      qual_nxt = qual_base + COUNT_BITS'(1);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_full_r      <= q_head.full;
      res_ok_r        <= ok;
      out_match_count <= qual_nxt;
    end
  end

  assign out_window_full = res_full_r;
  assign out_window_ok   = res_ok_r;

  // Sequence state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      qual_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (seq_clear) begin
        cnt_r  <= '0;
        qual_r <= '0;
      end else if (q_pop) begin
        cnt_r  <= cnt_nxt;
        qual_r <= qual_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sliding_window_base_count_check.sv */
// Top level of the sliding-window base-count check: configuration registers and wiring.
// Depends on swbc_pkg, swbc_front, swbc_fifo and swbc_back.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+--------------------------------------------------
//   input    | in_push / in_full  | in_base, in_start_new
//   result   | out_empty / out_pop| out_window_full, out_window_ok, out_match_count
//   config   | cfg_we             | cfg_index, cfg_data
//
// One request is taken every cycle while in_full is low; its result passes through the front
// stage, where the ring is read alongside, and through the queue before the back loads the
// result register.
// Reset is synchronous and active low; the ring needs no clearing pass, so requests are
// taken from the first cycle after reset.
// A stalled result side fills the result register, the four-entry queue and the front
// stage, then raises in_full.
`default_nettype none

module sliding_window_base_count_check import swbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [BASE_W-1:0]     in_base,
  input  wire logic                  in_start_new,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_window_full,
  output logic                       out_window_ok,
  output logic [COUNT_BITS-1:0]      out_match_count,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0] win_len_r;
  swbc_mins_t       mins_r;
  logic [LEN_W-1:0] len_eff;
  logic             seq_clear;

  logic       q_push, q_full, q_pop, q_empty;
  swbc_item_t q_in, q_head;

  // Window length is held already limited to one through the ring depth.
  always_comb begin
    if (cfg_data == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg_data) > 32'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(cfg_data);
    end
  end

  // A new window length starts a fresh sequence.
  assign seq_clear = cfg_we & (cfg_index == REG_WINDOW_LENGTH);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= LEN_W'(1);
      mins_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: win_len_r      <= len_eff;
        REG_MIN_A:         mins_r[BASE_A] <= cfg_data;
        REG_MIN_C:         mins_r[BASE_C] <= cfg_data;
        REG_MIN_G:         mins_r[BASE_G] <= cfg_data;
        REG_MIN_T:         mins_r[BASE_T] <= cfg_data;
        default: ;
      endcase
    end
  end

  swbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .seq_clear    (seq_clear),
    .win_len      (win_len_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_base      (in_base),
    .in_start_new (in_start_new),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  swbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  swbc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .seq_clear       (seq_clear),
    .mins            (mins_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_window_full (out_window_full),
    .out_window_ok   (out_window_ok),
    .out_match_count (out_match_count)
  );

`ifndef SYNTHESIS
  // The front never offers a request to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("request pushed into a full queue");

  // The back never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("request popped from an empty queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown straight after reset");

  // A qualifying window is always a full one.
  a_ok_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (!out_window_ok || out_window_full))
    else $error("window reported ok while not full");
`endif

endmodule

`default_nettype wire

/* test/tb_sliding_window_base_count_check.sv */
// Self-checking testbench for sliding_window_base_count_check: a queue-fed driver with a
// window predictor, a checking monitor, directed and random phases. Depends on swbc_pkg.
`timescale 1ns / 100ps

module tb_sliding_window_base_count_check;
  import swbc_pkg::*;

  // One symbol request as the driver sends it.
  typedef struct {
    logic [BASE_W-1:0] base;
    logic              start_new;
  } sym_req_t;

  // One predicted result.
  typedef struct {
    logic                  full;
    logic                  ok;
    logic [COUNT_BITS-1:0] hits;
  } window_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [BASE_W-1:0]     in_base = BASE_A;
  logic                  in_start_new = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_window_full;
  logic                  out_window_ok;
  logic [COUNT_BITS-1:0] out_match_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sym_req_t        symbol_queue[$];
  window_verdict_t verdict_queue[$];
  int              errors = 0;
  int              in_gap_max = 0;
  int              out_gap_max = 0;
  int              in_wait = 0;
  int              out_wait = 0;

  // Predictor state and its copy of the registers.
  logic [BASE_W-1:0]     ring_m [WINDOW_MAX];
  logic [PTR_W-1:0]      wr_ptr_m;
  logic [LEN_W-1:0]      fill_m;
  logic [LEN_W-1:0]      tally_m [NUM_BASES];
  logic [COUNT_BITS-1:0] matches_m;
  logic [CFG_DATA_W-1:0] length_reg_m;
  swbc_mins_t            mins_m;

  sliding_window_base_count_check uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_base         (in_base),
    .in_start_new    (in_start_new),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_window_full (out_window_full),
    .out_window_ok   (out_window_ok),
    .out_match_count (out_match_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The window length actually used: zero counts as one, large values are clamped.
  function automatic int window_span(logic [CFG_DATA_W-1:0] len);
    if (len == 0) return 1;
    if (int'(len) > WINDOW_MAX) return WINDOW_MAX;
    return int'(len);
  endfunction

  function automatic void clear_window();
    fill_m = '0;
    for (int b = 0; b < NUM_BASES; b++) tally_m[b] = '0;
    matches_m = '0;
  endfunction

  // Moves the window on by one symbol and returns the result it gives.
  function automatic window_verdict_t advance_window(logic [BASE_W-1:0] base, logic start);
    window_verdict_t v;
    int span;
    int oldest;
    logic [BASE_W-1:0] gone;
    span = window_span(length_reg_m);
    if (start) clear_window();
    if (int'(fill_m) >= span) begin
      oldest = (int'(wr_ptr_m) - int'(fill_m) + WINDOW_MAX) % WINDOW_MAX;
      gone = ring_m[oldest];
      if (tally_m[gone] != 0) tally_m[gone] = tally_m[gone] - LEN_W'(1);
      fill_m = fill_m - LEN_W'(1);
    end
    ring_m[wr_ptr_m] = base;
    tally_m[base] = tally_m[base] + LEN_W'(1);
    wr_ptr_m = wr_ptr_m + PTR_W'(1);
    fill_m = fill_m + LEN_W'(1);
    v.full = (int'(fill_m) == span);
    v.ok = v.full;
    for (int b = 0; b < NUM_BASES; b++)
      if (tally_m[b] < mins_m[b]) v.ok = 1'b0;
    if (v.ok && matches_m != '1) matches_m = matches_m + COUNT_BITS'(1);
    v.hits = matches_m;
    return v;
  endfunction

  // Driver: sends queued symbols, with a random pause after each request.
  sym_req_t next_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_push && !in_full)
        verdict_queue.push_back(advance_window(in_base, in_start_new));
      if (in_push && in_full) begin
        // Hold the request until it is taken.
      end else if (in_wait > 0) begin
        in_wait--;
        in_push <= 1'b0;
      end else if (symbol_queue.size() > 0) begin
        next_req = symbol_queue.pop_front();
        in_base <= next_req.base;
        in_start_new <= next_req.start_new;
        in_push <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, window_verdict_t exp);
    errors++;
    if (errors <= 10)
      $display({"mismatch (%s): expected full=%0b ok=%0b matches=%0d, ",
                "got full=%0b ok=%0b matches=%0d"},
               what, exp.full, exp.ok, exp.hits,
               out_window_full, out_window_ok, out_match_count);
  endtask

  // Monitor: takes results with random stalls and compares them with the oldest prediction.
  window_verdict_t exp_v;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_queue.size() == 0) begin
          exp_v = '{1'b0, 1'b0, '0};
          report_mismatch("unexpected result", exp_v);
        end else begin
          exp_v = verdict_queue.pop_front();
          if (out_window_full !== exp_v.full || out_window_ok !== exp_v.ok ||
              out_match_count !== exp_v.hits)
            report_mismatch("field", exp_v);
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Register write through the port, mirrored in the predictor.
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WINDOW_LENGTH: begin
        length_reg_m = val;
        clear_window();
      end
      REG_MIN_A: mins_m[BASE_A] = val;
      REG_MIN_C: mins_m[BASE_C] = val;
      REG_MIN_G: mins_m[BASE_G] = val;
      REG_MIN_T: mins_m[BASE_T] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mins(int a, int c, int g, int t);
    reg_write(REG_MIN_A, CFG_DATA_W'(a));
    reg_write(REG_MIN_C, CFG_DATA_W'(c));
    reg_write(REG_MIN_G, CFG_DATA_W'(g));
    reg_write(REG_MIN_T, CFG_DATA_W'(t));
  endtask

  task automatic queue_symbol(logic [BASE_W-1:0] base, logic start);
    symbol_queue.push_back('{base, start});
  endtask

  // Random symbols, optionally leaning towards one base so counts swing widely.
  task automatic queue_random(int n, int start_odds);
    logic [BASE_W-1:0] lean;
    logic [BASE_W-1:0] b;
    bit leaning;
    lean = BASE_W'($urandom_range(0, 3));
    leaning = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (leaning && $urandom_range(0, 9) < 6) b = lean;
      else b = BASE_W'($urandom_range(0, 3));
      queue_symbol(b, $urandom_range(0, start_odds - 1) == 0);
    end
  endtask

  task automatic pick_gaps();
    int pick;
    pick = $urandom_range(0, 2);
    in_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 18;
    pick = $urandom_range(0, 2);
    out_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 18;
  endtask

  // Waits, away from the clock edge, until every request has been sent and every
  // result taken.
  task automatic settle();
    while (symbol_queue.size() != 0 || in_push || verdict_queue.size() != 0 || !out_empty)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    int span;
    int len;
    int sel;
    int mins[NUM_BASES];
    for (int i = 0; i < WINDOW_MAX; i++) ring_m[i] = BASE_A;
    wr_ptr_m = '0;
    length_reg_m = CFG_DATA_W'(1);
    mins_m = '0;
    clear_window();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a window of one, all minimums zero, every base.
    in_gap_max = 18;
    out_gap_max = 0;
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_C, 1'b0);
    queue_symbol(BASE_G, 1'b0);
    queue_symbol(BASE_T, 1'b1);
    queue_symbol(BASE_A, 1'b0);
    settle();

    // Length zero behaves as one; a minimum of one A.
    in_gap_max = 0;
    out_gap_max = 18;
    reg_write(REG_WINDOW_LENGTH, '0);
    set_mins(1, 0, 0, 0);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_C, 1'b0);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_A, 1'b1);
    settle();

    // Window of three with a G minimum above the length: never qualifies.
    pick_gaps();
    reg_write(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
    set_mins(1, 0, 4, 0);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_C, 1'b0);
    queue_symbol(BASE_G, 1'b0);
    queue_symbol(BASE_T, 1'b0);
    settle();

    // Lower the G minimum without clearing; writes past the register list are ignored.
    reg_write(REG_MIN_G, '0);
    reg_write(3'd5, '1);
    reg_write(3'd6, '1);
    reg_write(3'd7, '1);
    reg_write(REG_MIN_T, CFG_DATA_W'(1));
    queue_symbol(BASE_T, 1'b0);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_T, 1'b0);
    queue_symbol(BASE_C, 1'b1);
    queue_symbol(BASE_A, 1'b0);
    queue_symbol(BASE_T, 1'b0);
    settle();

    // Random phases with short windows, occasional zero or oversized lengths.
    for (int p = 0; p < 8; p++) begin
      pick_gaps();
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) len = 0;
        else if (sel == 1) len = $urandom_range(WINDOW_MAX + 1, 2047);
        else len = $urandom_range(1, 12);
        reg_write(REG_WINDOW_LENGTH, CFG_DATA_W'(len));
      end
      span = window_span(length_reg_m);
      for (int b = 0; b < NUM_BASES; b++) begin
        sel = $urandom_range(0, 11);
        if (sel == 0) mins[b] = span + 1;
        else if (sel == 1) mins[b] = (span > 1) ? 2047 : 1024;
        else if (sel < 5) mins[b] = 0;
        else mins[b] = $urandom_range(0, span / 2 + 1);
      end
      set_mins(mins[0], mins[1], mins[2], mins[3]);
      queue_random($urandom_range(40, 75), 30);
      settle();
    end

    // A long window that fills and slides, then an oversized length clamped to the ring.
    pick_gaps();
    reg_write(REG_WINDOW_LENGTH, CFG_DATA_W'(240));
    set_mins($urandom_range(30, 60), $urandom_range(30, 60),
             $urandom_range(30, 60), $urandom_range(30, 60));
    queue_random(290, 1000000);
    settle();
    pick_gaps();
    reg_write(REG_WINDOW_LENGTH, '1);
    set_mins($urandom_range(0, 3), 0, 0, 1024);
    queue_random(40, 1000000);
    settle();

    repeat (10) @(posedge clk);
    if (errors == 0 && verdict_queue.size() == 0) begin
      $display("tb_sliding_window_base_count_check OK");
    end else begin
      $display("tb_sliding_window_base_count_check NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("tb_sliding_window_base_count_check NOT OK");
    $finish;
  end

endmodule

/* sliding_window_base_count_check.f */
hdl/swbc_pkg.sv
hdl/swbc_front.sv
hdl/swbc_fifo.sv
hdl/swbc_back.sv
hdl/sliding_window_base_count_check.sv
test/tb_sliding_window_base_count_check.sv
